// File: design/tsb_pkg.sv
// shared types and constants for the text screen buffer engine
// no dependencies; every other file uses it by scoped names
package tsb_pkg;

    localparam int OP_W       = 4;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 8;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 13;
    localparam int LINES_W    = 6;
    localparam int MASK_W     = 8;
    localparam int WREG_W     = 9;
    localparam int HREG_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int DIV_DW     = 14;
    localparam int DIV_VW     = 9;

    localparam logic [WREG_W-1:0]     WIDTH_RESET  = 9'd80;
    localparam logic [HREG_W-1:0]     HEIGHT_RESET = 6'd24;
    localparam logic [CHAR_W-1:0]     FILL_BYTE    = 8'h40;
    localparam logic [CFG_IDX_W-1:0]  REG_WIDTH_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_HEIGHT_IN_USE = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 4'd0,
        OP_SETCUR   = 4'd1,
        OP_RIGHT    = 4'd2,
        OP_LEFT     = 4'd3,
        OP_UP       = 4'd4,
        OP_DOWN     = 4'd5,
        OP_SETTEMP  = 4'd6,
        OP_GOTEMP   = 4'd7,
        OP_WRITE    = 4'd8,
        OP_WRITEAT  = 4'd9,
        OP_DEL      = 4'd10,
        OP_INS      = 4'd11,
        OP_ROLL     = 4'd12,
        OP_READ     = 4'd13,
        OP_INDSET   = 4'd14,
        OP_INDCLR   = 4'd15
    } t_op;

    typedef struct packed {
        t_op                        operation;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic [CHAR_W-1:0]          char_value;
        logic [CNT_W-1:0]           count;
        logic signed [LINES_W-1:0]  lines;
        logic [ROW_W-1:0]           top_row;
        logic [ROW_W-1:0]           bottom_row;
        logic [MASK_W-1:0]          mask;
    } t_item;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [ROW_W-1:0]  cursor_row_out;
        logic [COL_W-1:0]  cursor_col_out;
        logic [MASK_W-1:0] indicators_out;
        logic              status;
    } t_result;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_SCRUB,
        DP_LOAD,
        DP_EXEC,
        DP_RD_CAP,
        DP_CLR,
        DP_DIV_A,
        DP_DIV_B,
        DP_DIV_END,
        DP_DEL_RD,
        DP_DEL_WR,
        DP_DEL_FILL,
        DP_INS_RD,
        DP_INS_WR,
        DP_INS_END,
        DP_ROLL_RD,
        DP_ROLL_WR,
        DP_OUT
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic pos_ok;
        logic cnt_zero;
        logic cnt_one;
        logic walk_last;
        logic col_last;
        logic row_last;
        logic roll_bad;
        logic roll_empty;
        logic div_done;
        logic scrub_last;
        logic out_free;
    } t_dp_status;

    typedef enum logic [4:0] {
        S_SCRUB,
        S_IDLE,
        S_EXEC,
        S_RDCAP,
        S_CLR,
        S_DIVA,
        S_WAITA,
        S_DIVB,
        S_WAITB,
        S_DIVEND,
        S_DRD,
        S_DWR,
        S_DFILL,
        S_IRD,
        S_IWR,
        S_IEND,
        S_RRD,
        S_RWR,
        S_FIN
    } t_state;

endpackage

// File: design/tsb_intf.sv
// channel interfaces: command, response and configuration write
// depends on tsb_pkg for field widths
interface tsb_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [tsb_pkg::OP_W-1:0]            operation;
    logic [tsb_pkg::ROW_W-1:0]           row;
    logic [tsb_pkg::COL_W-1:0]           col;
    logic [tsb_pkg::CHAR_W-1:0]          char_value;
    logic [tsb_pkg::CNT_W-1:0]           count;
    logic signed [tsb_pkg::LINES_W-1:0]  lines;
    logic [tsb_pkg::ROW_W-1:0]           top_row;
    logic [tsb_pkg::ROW_W-1:0]           bottom_row;
    logic [tsb_pkg::MASK_W-1:0]          mask;
    modport source (output valid, operation, row, col, char_value, count, lines,
                    top_row, bottom_row, mask, input ready);
    modport sink (input valid, operation, row, col, char_value, count, lines,
                  top_row, bottom_row, mask, output ready);
endinterface

interface tsb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tsb_pkg::CHAR_W-1:0]  read_char;
    logic [tsb_pkg::ROW_W-1:0]   cursor_row_out;
    logic [tsb_pkg::COL_W-1:0]   cursor_col_out;
    logic [tsb_pkg::MASK_W-1:0]  indicators_out;
    logic                        status;
    modport source (output valid, read_char, cursor_row_out, cursor_col_out,
                    indicators_out, status, input ready);
    modport sink (input valid, read_char, cursor_row_out, cursor_col_out,
                  indicators_out, status, output ready);
endinterface

interface tsb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tsb_pkg::CFG_IDX_W-1:0]   index;
    logic [tsb_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/tsb_div.sv
// restoring divider, one quotient bit per cycle
// depends on tsb_pkg for operand widths
module tsb_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tsb_pkg::DIV_DW-1:0]  i_dividend,
    input  logic [tsb_pkg::DIV_VW-1:0]  i_divisor,
    output logic                        o_done,
    output logic [tsb_pkg::DIV_DW-1:0]  o_quot,
    output logic [tsb_pkg::DIV_VW-1:0]  o_rem
);
    localparam int DW = tsb_pkg::DIV_DW;
    localparam int VW = tsb_pkg::DIV_VW;
    localparam int SW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [SW-1:0] r_steps;
    logic          r_done;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_q[DW-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_steps == SW'(1)) && !i_start;
            if (i_start) begin
                r_steps <= SW'(DW);
            end else if (r_steps != '0) begin
                r_steps <= r_steps - SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_steps != '0) begin
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_q   <= {r_q[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// File: design/tsb_ctrl.sv
// command sequencer: picks one datapath action per cycle
// depends on tsb_pkg for state, action and status types
module tsb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  tsb_pkg::t_dp_status  i_stat,
    output logic                 o_in_ready,
    output tsb_pkg::t_dp_cmd     o_cmd
);
    tsb_pkg::t_state r_state;
    tsb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsb_pkg::S_SCRUB;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tsb_pkg::S_SCRUB: if (i_stat.scrub_last) n_state = tsb_pkg::S_IDLE;
            tsb_pkg::S_IDLE:  if (i_in_valid) n_state = tsb_pkg::S_EXEC;
            tsb_pkg::S_EXEC: begin
                case (i_stat.op)
                    tsb_pkg::OP_CLEAR: n_state = tsb_pkg::S_CLR;
                    tsb_pkg::OP_RIGHT: n_state = tsb_pkg::S_DIVA;
                    tsb_pkg::OP_DEL:
                        n_state = i_stat.cnt_zero ? tsb_pkg::S_DFILL : tsb_pkg::S_DRD;
                    tsb_pkg::OP_INS:
                        n_state = i_stat.cnt_zero ? tsb_pkg::S_IEND : tsb_pkg::S_IRD;
                    tsb_pkg::OP_ROLL:
                        n_state = (i_stat.roll_bad || i_stat.roll_empty) ?
                                  tsb_pkg::S_FIN : tsb_pkg::S_RRD;
                    tsb_pkg::OP_READ:
                        n_state = i_stat.pos_ok ? tsb_pkg::S_RDCAP : tsb_pkg::S_FIN;
                    default: n_state = tsb_pkg::S_FIN;
                endcase
            end
            tsb_pkg::S_RDCAP:  n_state = tsb_pkg::S_FIN;
            tsb_pkg::S_CLR:    if (i_stat.walk_last) n_state = tsb_pkg::S_FIN;
            tsb_pkg::S_DIVA:   n_state = tsb_pkg::S_WAITA;
            tsb_pkg::S_WAITA:  if (i_stat.div_done) n_state = tsb_pkg::S_DIVB;
            tsb_pkg::S_DIVB:   n_state = tsb_pkg::S_WAITB;
            tsb_pkg::S_WAITB:  if (i_stat.div_done) n_state = tsb_pkg::S_DIVEND;
            tsb_pkg::S_DIVEND: n_state = tsb_pkg::S_FIN;
            tsb_pkg::S_DRD:    n_state = tsb_pkg::S_DWR;
            tsb_pkg::S_DWR:
                n_state = i_stat.cnt_one ? tsb_pkg::S_DFILL : tsb_pkg::S_DRD;
            tsb_pkg::S_DFILL:  n_state = tsb_pkg::S_FIN;
            tsb_pkg::S_IRD:    n_state = tsb_pkg::S_IWR;
            tsb_pkg::S_IWR:
                n_state = i_stat.cnt_one ? tsb_pkg::S_IEND : tsb_pkg::S_IRD;
            tsb_pkg::S_IEND:   n_state = tsb_pkg::S_FIN;
            tsb_pkg::S_RRD:    n_state = tsb_pkg::S_RWR;
            tsb_pkg::S_RWR:
                n_state = (i_stat.col_last && i_stat.row_last) ?
                          tsb_pkg::S_FIN : tsb_pkg::S_RRD;
            tsb_pkg::S_FIN:    if (i_stat.out_free) n_state = tsb_pkg::S_IDLE;
            default:           n_state = tsb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = tsb_pkg::DP_NOP;
        case (r_state)
            tsb_pkg::S_SCRUB:  o_cmd = tsb_pkg::DP_SCRUB;
            tsb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd      = i_in_valid ? tsb_pkg::DP_LOAD : tsb_pkg::DP_NOP;
            end
            tsb_pkg::S_EXEC:   o_cmd = tsb_pkg::DP_EXEC;
            tsb_pkg::S_RDCAP:  o_cmd = tsb_pkg::DP_RD_CAP;
            tsb_pkg::S_CLR:    o_cmd = tsb_pkg::DP_CLR;
            tsb_pkg::S_DIVA:   o_cmd = tsb_pkg::DP_DIV_A;
            tsb_pkg::S_DIVB:   o_cmd = tsb_pkg::DP_DIV_B;
            tsb_pkg::S_DIVEND: o_cmd = tsb_pkg::DP_DIV_END;
            tsb_pkg::S_DRD:    o_cmd = tsb_pkg::DP_DEL_RD;
            tsb_pkg::S_DWR:    o_cmd = tsb_pkg::DP_DEL_WR;
            tsb_pkg::S_DFILL:  o_cmd = tsb_pkg::DP_DEL_FILL;
            tsb_pkg::S_IRD:    o_cmd = tsb_pkg::DP_INS_RD;
            tsb_pkg::S_IWR:    o_cmd = tsb_pkg::DP_INS_WR;
            tsb_pkg::S_IEND:   o_cmd = tsb_pkg::DP_INS_END;
            tsb_pkg::S_RRD:    o_cmd = tsb_pkg::DP_ROLL_RD;
            tsb_pkg::S_RWR:    o_cmd = tsb_pkg::DP_ROLL_WR;
            tsb_pkg::S_FIN:
                o_cmd = i_stat.out_free ? tsb_pkg::DP_OUT : tsb_pkg::DP_NOP;
            default:           o_cmd = tsb_pkg::DP_NOP;
        endcase
    end
endmodule

// File: design/tsb_dp.sv
// datapath: screen memory, cursor, walk pointer, roll rows, result register
// depends on tsb_pkg and tsb_div
module tsb_dp #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tsb_pkg::WREG_W-1:0]  i_w,
    input  logic [tsb_pkg::HREG_W-1:0]  i_h,
    input  tsb_pkg::t_dp_cmd            i_cmd,
    input  tsb_pkg::t_item              i_item,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output tsb_pkg::t_result            o_result,
    output tsb_pkg::t_dp_status         o_stat
);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;

    logic [7:0] mem [DEPTH];

    logic [RW-1:0] r_cur_row, r_sav_row, r_wr;
    logic [CW-1:0] r_cur_col, r_sav_col, r_wc;
    logic [7:0]    r_ind;
    logic          r_out_valid;
    logic [AW-1:0] r_scrub;

    tsb_pkg::t_op           r_op;
    logic [4:0]             r_row, r_top, r_bot;
    logic [7:0]             r_col, r_char, r_mask, r_carry, r_rdata, r_rd_char;
    logic [12:0]            r_cnt;
    logic [5:0]             r_lines;
    logic [5:0]             r_src, r_dst;
    logic                   r_status;
    tsb_pkg::t_result       r_result;

    logic [RW-1:0] cur_row_sat, sav_row_sat, h_last_row;
    logic [CW-1:0] cur_col_sat, sav_col_sat, w_last_col;
    logic [AW-1:0] cur_next, walk_next;
    logic          pos_ok, col_last, walk_last, row_last, roll_bad, roll_empty;
    logic [5:0]    l_abs, in_abs, in_lraw;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata;

    logic                        div_start, div_done;
    logic [tsb_pkg::DIV_DW-1:0]  div_dividend, div_quot;
    logic [tsb_pkg::DIV_VW-1:0]  div_divisor, div_rem;

    function automatic logic [AW-1:0] f_adv(input logic [RW-1:0] r,
                                            input logic [CW-1:0] c,
                                            input logic [8:0] w,
                                            input logic [5:0] h);
        logic [RW-1:0] nr;
        logic [CW-1:0] nc;
        if (9'(c) + 9'd1 >= w) begin
            nc = '0;
            nr = (7'(r) + 7'd1 >= 7'(h)) ? '0 : r + RW'(1);
        end else begin
            nc = c + CW'(1);
            nr = r;
        end
        return {nr, nc};
    endfunction

    assign h_last_row  = RW'(i_h - 6'd1);
    assign w_last_col  = CW'(i_w - 9'd1);
    assign cur_row_sat = (7'(r_cur_row) >= 7'(i_h)) ? h_last_row : r_cur_row;
    assign cur_col_sat = (9'(r_cur_col) >= i_w) ? w_last_col : r_cur_col;
    assign sav_row_sat = (7'(r_sav_row) >= 7'(i_h)) ? h_last_row : r_sav_row;
    assign sav_col_sat = (9'(r_sav_col) >= i_w) ? w_last_col : r_sav_col;
    assign cur_next    = f_adv(r_cur_row, r_cur_col, i_w, i_h);
    assign walk_next   = f_adv(r_wr, r_wc, i_w, i_h);

    assign pos_ok    = (6'(r_row) < i_h) && (9'(r_col) < i_w);
    assign col_last  = (9'(r_wc) + 9'd1 >= i_w);
    assign walk_last = col_last && (7'(r_wr) + 7'd1 >= 7'(i_h));

    // roll distance magnitude, latched and incoming
    assign l_abs      = r_lines[5] ? 6'(~r_lines + 6'd1) : r_lines;
    assign in_lraw    = i_item.lines;
    assign in_abs     = in_lraw[5] ? 6'(~in_lraw + 6'd1) : in_lraw;
    assign roll_bad   = (6'(r_top) >= i_h) || (6'(r_bot) >= i_h);
    assign roll_empty = (r_lines == 6'd0) || (7'(r_top) + 7'(l_abs) > 7'(r_bot));
    assign row_last   = r_src == (r_lines[5] ? 6'(r_bot) : 6'(r_top));

    // memory ports
    always_comb begin
        we    = 1'b0;
        waddr = {r_wr, r_wc};
        wdata = '0;
        raddr = {r_wr, r_wc};
        case (i_cmd)
            tsb_pkg::DP_SCRUB: begin
                we    = 1'b1;
                waddr = r_scrub;
            end
            tsb_pkg::DP_EXEC: begin
                raddr = {RW'(r_row), CW'(r_col)};
                if (r_op == tsb_pkg::OP_WRITE) begin
                    we    = 1'b1;
                    waddr = {r_cur_row, r_cur_col};
                    wdata = r_char;
                end else if (r_op == tsb_pkg::OP_WRITEAT && pos_ok) begin
                    we    = 1'b1;
                    waddr = {RW'(r_row), CW'(r_col)};
                    wdata = r_char;
                end
            end
            tsb_pkg::DP_CLR:      we = 1'b1;
            tsb_pkg::DP_DEL_RD:   raddr = walk_next;
            tsb_pkg::DP_DEL_WR: begin
                we    = 1'b1;
                wdata = r_rdata;
            end
            tsb_pkg::DP_DEL_FILL: begin
                we    = 1'b1;
                wdata = tsb_pkg::FILL_BYTE;
            end
            tsb_pkg::DP_INS_WR: begin
                we    = 1'b1;
                wdata = r_carry;
            end
            tsb_pkg::DP_ROLL_RD:  raddr = {RW'(r_src), r_wc};
            tsb_pkg::DP_ROLL_WR: begin
                we    = 1'b1;
                waddr = {RW'(r_dst), r_wc};
                wdata = r_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    assign div_start    = (i_cmd == tsb_pkg::DP_DIV_A) || (i_cmd == tsb_pkg::DP_DIV_B);
    assign div_dividend = (i_cmd == tsb_pkg::DP_DIV_A) ?
                          14'(r_cur_col) + 14'(r_cnt) : div_quot + 14'(r_cur_row);
    assign div_divisor  = (i_cmd == tsb_pkg::DP_DIV_A) ? i_w : 9'(i_h);

    tsb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // cursor, saved cursor, indicators, result valid, scrub address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_sav_row   <= '0;
            r_sav_col   <= '0;
            r_ind       <= '0;
            r_out_valid <= 1'b0;
            r_scrub     <= '0;
        end else begin
            if (i_cmd == tsb_pkg::DP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                tsb_pkg::DP_SCRUB: r_scrub <= r_scrub + AW'(1);
                tsb_pkg::DP_LOAD: begin
                    if (i_item.operation == tsb_pkg::OP_CLEAR) begin
                        r_cur_row <= '0;
                        r_cur_col <= '0;
                    end else begin
                        r_cur_row <= cur_row_sat;
                        r_cur_col <= cur_col_sat;
                    end
                end
                tsb_pkg::DP_EXEC: begin
                    case (r_op)
                        tsb_pkg::OP_SETCUR: if (pos_ok) begin
                            r_cur_row <= RW'(r_row);
                            r_cur_col <= CW'(r_col);
                        end
                        tsb_pkg::OP_LEFT: begin
                            if (r_cur_col == '0) begin
                                r_cur_col <= w_last_col;
                                r_cur_row <= (r_cur_row == '0) ? h_last_row :
                                             r_cur_row - RW'(1);
                            end else begin
                                r_cur_col <= r_cur_col - CW'(1);
                            end
                        end
                        tsb_pkg::OP_UP:
                            r_cur_row <= (r_cur_row == '0) ? h_last_row : r_cur_row - RW'(1);
                        tsb_pkg::OP_DOWN:
                            r_cur_row <= (7'(r_cur_row) + 7'd1 >= 7'(i_h)) ? '0 :
                                         r_cur_row + RW'(1);
                        tsb_pkg::OP_SETTEMP: if (pos_ok) begin
                            r_sav_row <= RW'(r_row);
                            r_sav_col <= CW'(r_col);
                        end
                        tsb_pkg::OP_GOTEMP: begin
                            r_cur_row <= sav_row_sat;
                            r_cur_col <= sav_col_sat;
                        end
                        tsb_pkg::OP_WRITE: {r_cur_row, r_cur_col} <= cur_next;
                        tsb_pkg::OP_INDSET: r_ind <= r_ind | r_mask;
                        tsb_pkg::OP_INDCLR: r_ind <= r_ind & ~r_mask;
                        default: ;
                    endcase
                end
                tsb_pkg::DP_DIV_B:   r_cur_col <= CW'(div_rem);
                tsb_pkg::DP_DIV_END: r_cur_row <= RW'(div_rem);
                tsb_pkg::DP_INS_END: {r_cur_row, r_cur_col} <= cur_next;
                default: ;
            endcase
        end
    end

    // command operands, walk pointer and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            tsb_pkg::DP_LOAD: begin
                r_op      <= i_item.operation;
                r_row     <= i_item.row;
                r_col     <= i_item.col;
                r_char    <= i_item.char_value;
                r_cnt     <= i_item.count;
                r_lines   <= in_lraw;
                r_top     <= i_item.top_row;
                r_bot     <= i_item.bottom_row;
                r_mask    <= i_item.mask;
                r_carry   <= i_item.char_value;
                r_status  <= 1'b0;
                r_rd_char <= '0;
                if (i_item.operation == tsb_pkg::OP_CLEAR ||
                    i_item.operation == tsb_pkg::OP_ROLL) begin
                    r_wr <= '0;
                    r_wc <= '0;
                end else begin
                    r_wr <= cur_row_sat;
                    r_wc <= cur_col_sat;
                end
                // text up walks rows downward from the top, text down walks upward from the bottom
                if (in_lraw[5]) begin
                    r_src <= 6'(i_item.top_row) + in_abs;
                    r_dst <= 6'(i_item.top_row);
                end else begin
                    r_src <= 6'(i_item.bottom_row) - in_abs;
                    r_dst <= 6'(i_item.bottom_row);
                end
            end
            tsb_pkg::DP_EXEC: begin
                if ((r_op == tsb_pkg::OP_SETCUR || r_op == tsb_pkg::OP_SETTEMP ||
                     r_op == tsb_pkg::OP_WRITEAT || r_op == tsb_pkg::OP_READ) && !pos_ok) begin
                    r_status <= 1'b1;
                end
                if (r_op == tsb_pkg::OP_ROLL && roll_bad) begin
                    r_status <= 1'b1;
                end
            end
            tsb_pkg::DP_RD_CAP: r_rd_char <= r_rdata;
            tsb_pkg::DP_CLR: begin
                if (col_last) begin
                    r_wc <= '0;
                    r_wr <= r_wr + RW'(1);
                end else begin
                    r_wc <= r_wc + CW'(1);
                end
            end
            tsb_pkg::DP_DEL_WR: begin
                {r_wr, r_wc} <= walk_next;
                r_cnt        <= r_cnt - 13'd1;
            end
            tsb_pkg::DP_INS_WR: begin
                r_carry      <= r_rdata;
                {r_wr, r_wc} <= walk_next;
                r_cnt        <= r_cnt - 13'd1;
            end
            tsb_pkg::DP_ROLL_WR: begin
                if (col_last) begin
                    r_wc <= '0;
                    if (r_lines[5]) begin
                        r_src <= r_src + 6'd1;
                        r_dst <= r_dst + 6'd1;
                    end else begin
                        r_src <= r_src - 6'd1;
                        r_dst <= r_dst - 6'd1;
                    end
                end else begin
                    r_wc <= r_wc + CW'(1);
                end
            end
            tsb_pkg::DP_OUT: begin
                r_result.read_char      <= r_rd_char;
                r_result.cursor_row_out <= 5'(r_cur_row);
                r_result.cursor_col_out <= 8'(r_cur_col);
                r_result.indicators_out <= r_ind;
                r_result.status         <= r_status;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.pos_ok     = pos_ok;
        o_stat.cnt_zero   = (r_cnt == 13'd0);
        o_stat.cnt_one    = (r_cnt == 13'd1);
        o_stat.walk_last  = walk_last;
        o_stat.col_last   = col_last;
        o_stat.row_last   = row_last;
        o_stat.roll_bad   = roll_bad;
        o_stat.roll_empty = roll_empty;
        o_stat.div_done   = div_done;
        o_stat.scrub_last = &r_scrub;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end
endmodule

// File: design/text_screen_buffer_engine.sv
// top level of the text screen buffer engine: config registers, sequencer, datapath
// depends on tsb_pkg, tsb_intf, tsb_ctrl and tsb_dp
//
// channel   dir  handshake            payload
// i_cmd     in   valid/ready          operation, row, col, char_value, count, lines,
//                                     top_row, bottom_row, mask
// o_rsp     out  valid/ready          read_char, cursor_row_out, cursor_col_out,
//                                     indicators_out, status
// i_cfg     in   valid/ready (ready   index, data (0 width_in_use, 1 height_in_use)
//                tied high)
//
// per command: cursor, indicator and write commands need only the execute step, read adds
// a capture step, right by count makes two passes through the 14-step divider,
// clear walks all W*H cells, delete and insert read and write once per count, roll reads
// and writes each moved cell; the screen memory's registered read splits each move into a read and a write step
// after reset the memory is zeroed one cell a cycle, all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS))
// cells (8192 by default), with i_cmd.ready low; config writes are taken throughout
// the result register lets the next command be taken while a response stalls
module text_screen_buffer_engine #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsb_cmd_if.sink    i_cmd,
    tsb_rsp_if.source  o_rsp,
    tsb_cfg_if.sink    i_cfg
);
    // configuration registers
    logic [tsb_pkg::WREG_W-1:0] r_width_in_use;
    logic [tsb_pkg::HREG_W-1:0] r_height_in_use;

    // grid size saturated into the legal range
    logic [tsb_pkg::WREG_W-1:0] grid_w;
    logic [tsb_pkg::HREG_W-1:0] grid_h;

    tsb_pkg::t_item      item;
    tsb_pkg::t_result    result;
    tsb_pkg::t_dp_cmd    dp_cmd;
    tsb_pkg::t_dp_status dp_stat;
    logic                in_ready;
    logic                out_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_in_use  <= tsb_pkg::WIDTH_RESET;
            r_height_in_use <= tsb_pkg::HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            // writes to unused indexes are dropped
            if (i_cfg.index == tsb_pkg::REG_WIDTH_IN_USE) begin
                r_width_in_use <= i_cfg.data;
            end else if (i_cfg.index == tsb_pkg::REG_HEIGHT_IN_USE) begin
                r_height_in_use <= i_cfg.data[tsb_pkg::HREG_W-1:0];
            end
        end
    end

    assign grid_w = (r_width_in_use == '0) ? 9'd1 :
                    (r_width_in_use > 9'(MAX_COLS)) ? 9'(MAX_COLS) : r_width_in_use;
    assign grid_h = (r_height_in_use == '0) ? 6'd1 :
                    (7'(r_height_in_use) > 7'(MAX_ROWS)) ? 6'(MAX_ROWS) : r_height_in_use;

    // pack the command channel into one item
    assign item.operation  = tsb_pkg::t_op'(i_cmd.operation);
    assign item.row        = i_cmd.row;
    assign item.col        = i_cmd.col;
    assign item.char_value = i_cmd.char_value;
    assign item.count      = i_cmd.count;
    assign item.lines      = i_cmd.lines;
    assign item.top_row    = i_cmd.top_row;
    assign item.bottom_row = i_cmd.bottom_row;
    assign item.mask       = i_cmd.mask;

    assign i_cmd.ready = in_ready;

    tsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_stat     (dp_stat),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    tsb_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_w         (grid_w),
        .i_h         (grid_h),
        .i_cmd       (dp_cmd),
        .i_item      (item),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_result    (result),
        .o_stat      (dp_stat)
    );

    // response channel straight from the result register
    assign o_rsp.valid          = out_valid;
    assign o_rsp.read_char      = result.read_char;
    assign o_rsp.cursor_row_out = result.cursor_row_out;
    assign o_rsp.cursor_col_out = result.cursor_col_out;
    assign o_rsp.indicators_out = result.indicators_out;
    assign o_rsp.status         = result.status;
endmodule
